@@ rtl/lcdt_pkg.sv @@
// Shared constants and types for the LCD mode timing controller.
package lcdt_pkg;

  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  localparam logic [9:0] LEN_OAM    = 10'd80;
  localparam logic [9:0] LEN_XFER   = 10'd172;
  localparam logic [9:0] LEN_HBLANK = 10'd204;
  localparam logic [9:0] LEN_LINE   = LEN_OAM + LEN_XFER + LEN_HBLANK;

  localparam logic [7:0] VISIBLE_LINES = 8'd144;
  localparam logic [7:0] TOTAL_LINES   = 8'd154;

  localparam logic [1:0] REG_HBLANK_IRQ_EN = 2'd0;
  localparam logic [1:0] REG_MATCH_IRQ_EN  = 2'd1;
  localparam logic [1:0] REG_LINE_COMPARE  = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [9:0] count;
    logic [7:0] line;
    logic       match;
  } timing_state_t;

  typedef struct packed {
    logic       hblank_irq_enable;
    logic       line_match_irq_enable;
    logic [7:0] line_compare;
  } timing_cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] line_number;
    logic       line_match;
    logic       stat_irq;
    logic       vblank_irq;
    logic       scanline_done;
    logic       frame_done;
  } timing_res_t;

endpackage

@@ rtl/lcdt_step.sv @@
// Next-state and result logic for one cycle-count word.
module lcdt_step
  import lcdt_pkg::*;
(
  input  timing_state_t st,
  input  timing_cfg_t   cfg,
  input  logic [5:0]    cycles,
  output timing_state_t st_nxt,
  output timing_res_t   res
);

  logic [9:0] sum;
  logic [9:0] len;
  logic [7:0] line_inc;
  logic       eq;

  assign sum      = st.count + {4'd0, cycles};
  assign line_inc = st.line + 8'd1;
  assign eq       = (cfg.line_compare == st.line);

  always_comb begin
    case (st.mode)
      MODE_OAM:    len = LEN_OAM;
      MODE_XFER:   len = LEN_XFER;
      MODE_HBLANK: len = LEN_HBLANK;
      default:     len = LEN_LINE;
    endcase
  end

  always_comb begin
    st_nxt            = st;
    st_nxt.count      = sum;
    res.stat_irq      = 1'b0;
    res.vblank_irq    = 1'b0;
    res.scanline_done = 1'b0;
    res.frame_done    = 1'b0;
    if (sum >= len) begin
      st_nxt.count = sum - len;
      case (st.mode)
        MODE_OAM: begin
          st_nxt.mode = MODE_XFER;
        end
        MODE_XFER: begin
          res.stat_irq = cfg.hblank_irq_enable | (cfg.line_match_irq_enable & eq);
          st_nxt.match = eq;
          st_nxt.mode  = MODE_HBLANK;
        end
        MODE_HBLANK: begin
          res.scanline_done = 1'b1;
          st_nxt.line       = line_inc;
          if (line_inc == VISIBLE_LINES) begin
            res.vblank_irq = 1'b1;
            st_nxt.mode    = MODE_VBLANK;
          end else begin
            st_nxt.mode = MODE_OAM;
          end
        end
        default: begin
          // Vertical blank: one line each time the count reaches LEN_LINE (456), wrapping after the last one.
          st_nxt.line = line_inc;
          if (line_inc == TOTAL_LINES) begin
            res.frame_done = 1'b1;
            st_nxt.line    = 8'd0;
            st_nxt.mode    = MODE_OAM;
          end
        end
      endcase
    end
    res.mode        = st_nxt.mode;
    res.line_number = st_nxt.line;
    res.line_match  = st_nxt.match;
  end

endmodule

@@ rtl/lcd_mode_timing_controller.sv @@
// Top level of the LCD mode timing controller: input register, step logic, result register.
//
//   channel  | direction | ports
//   ---------+-----------+------------------------------------------------------
//   in_      | input     | in_valid, in_stall, in_cycles
//   out_     | output    | out_valid, out_stall, out_mode .. out_frame_done
//   config   | APB       | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// Each word passes an input register and then a result register; one word is accepted
// per cycle while the result side does not stall.
// Reset (synchronous, rst_n low) sets OAM scan, line 0, count 0 and clears config.
// A stall on the result side holds both stages; in_stall rises only when the
// input register is full and cannot move forward.
module lcd_mode_timing_controller
  import lcdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  in_cycles,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_mode,
  output logic [7:0]  out_line_number,
  output logic        out_line_match,
  output logic        out_stat_irq,
  output logic        out_vblank_irq,
  output logic        out_scanline_done,
  output logic        out_frame_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  timing_cfg_t   cfg_r;
  timing_state_t st_r;
  timing_state_t st_nxt;
  timing_res_t   res_nxt;
  timing_res_t   res_r;
  logic          in_valid_r;
  logic [5:0]    in_cycles_r;
  logic          out_valid_r;
  logic          out_load;
  logic          advance;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_HBLANK_IRQ_EN: cfg_r.hblank_irq_enable     <= pwdata[0];
        REG_MATCH_IRQ_EN:  cfg_r.line_match_irq_enable <= pwdata[0];
        REG_LINE_COMPARE:  cfg_r.line_compare          <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HBLANK_IRQ_EN: prdata = {31'd0, cfg_r.hblank_irq_enable};
      REG_MATCH_IRQ_EN:  prdata = {31'd0, cfg_r.line_match_irq_enable};
      REG_LINE_COMPARE:  prdata = {24'd0, cfg_r.line_compare};
      default:           prdata = 32'd0;
    endcase
  end

  assign out_load = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_load;
  assign in_stall = in_valid_r && !out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_cycles_r <= in_cycles;
    end
  end

  lcdt_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .cycles (in_cycles_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // Timing state moves only when a word leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode  <= MODE_OAM;
      st_r.count <= 10'd0;
      st_r.line  <= 8'd0;
      st_r.match <= 1'b0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mode          = res_r.mode;
  assign out_line_number   = res_r.line_number;
  assign out_line_match    = res_r.line_match;
  assign out_stat_irq      = res_r.stat_irq;
  assign out_vblank_irq    = res_r.vblank_irq;
  assign out_scanline_done = res_r.scanline_done;
  assign out_frame_done    = res_r.frame_done;

`ifndef NO_ASSERTIONS
  a_vblank_lines: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.mode == MODE_VBLANK) |-> (st_r.line >= VISIBLE_LINES && st_r.line < TOTAL_LINES))
    else $error("vertical blank outside its line range");

  a_visible_lines: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.mode != MODE_VBLANK) |-> (st_r.line < VISIBLE_LINES))
    else $error("visible mode on a blank line");

  a_vblank_irq_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.vblank_irq) |-> (res_r.mode == MODE_VBLANK
      && res_r.line_number == VISIBLE_LINES && res_r.scanline_done))
    else $error("vblank pulse without entry into vertical blank");

  a_frame_done_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.frame_done) |-> (res_r.mode == MODE_OAM
      && res_r.line_number == 8'd0 && !res_r.stat_irq))
    else $error("frame end without wrap to line zero");
`endif

endmodule
